// ===== design/ihrl_pkg.sv =====
// shared types and constants of the intel hex record loader
`timescale 1ns / 1ps

package ihrl_pkg;

  // longest record body that is accepted, in bytes
  localparam int unsigned MaxRecordBytes = 256;

  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharLowA  = 8'h61;

  localparam logic [7:0] RecData  = 8'h00;
  localparam logic [7:0] RecEof   = 8'h01;
  localparam logic [7:0] RecUpper = 8'h04;

  typedef enum logic [1:0] {
    KindData   = 2'd0,
    KindRecEnd = 2'd1,
    KindDone   = 2'd2,
    KindFail   = 2'd3
  } kind_e;

  typedef enum logic [6:0] {
    PhAwait  = 7'b0000001,
    PhHeader = 7'b0000010,
    PhData   = 7'b0000100,
    PhCheck  = 7'b0001000,
    PhSkip   = 7'b0010000,
    PhDone   = 7'b0100000,
    PhFailed = 7'b1000000
  } phase_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [31:0] load_address;
    logic [7:0]  data_byte;
    logic [7:0]  record_kind;
  } result_t;

  // the file's digit rule, including its handling of non-hex characters
  function automatic logic [7:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c < CharUpA) begin
      v = c - CharZero;
    end else if (c < CharLowA) begin
      v = 8'd10 + c - CharUpA;
    end else begin
      v = 8'd10 + c - CharLowA;
    end
    return v;
  endfunction

endpackage

// ===== design/ihrl_parser.sv =====
// record parser: decode state and the per-character step logic
`timescale 1ns / 1ps

module ihrl_parser #(
  parameter int unsigned MaxRecordBytes = ihrl_pkg::MaxRecordBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [7:0]        char_i,
  input  logic              eof_i,
  output ihrl_pkg::result_t res_o
);

  ihrl_pkg::phase_e phase_q, phase_d;
  logic [8:0]  digit_q, digit_d;
  logic [3:0]  nibble_q, nibble_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  type_q, type_d;
  logic [15:0] upper_q, upper_d;
  logic [7:0]  fdb0_q, fdb0_d;
  logic [7:0]  fdb1_q, fdb1_d;

  logic [7:0]  dval;
  logic [7:0]  pair;
  logic [2:0]  hdr_k;
  logic [7:0]  pos;
  logic [9:0]  idx_next;
  logic [15:0] addr_term;

  assign dval  = ihrl_pkg::digit_value(char_i);
  assign pair  = {nibble_q, 4'b0000} + dval;
  assign hdr_k = digit_q[2:0];
  assign pos   = digit_q[8:1];
  assign idx_next = {1'b0, digit_q} + 10'd1;

  always_comb begin
    unique case (hdr_k)
      3'd2:    addr_term = {dval[3:0], 12'h000};
      3'd3:    addr_term = {dval, 8'h00};
      3'd4:    addr_term = {4'h0, dval, 4'h0};
      3'd5:    addr_term = {8'h00, dval};
      default: addr_term = 16'h0000;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    digit_d  = digit_q;
    nibble_d = nibble_q;
    len_d    = len_q;
    addr_d   = addr_q;
    type_d   = type_q;
    upper_d  = upper_q;
    fdb0_d   = fdb0_q;
    fdb1_d   = fdb1_q;
    res_o    = '0;

    if (phase_q == ihrl_pkg::PhDone || phase_q == ihrl_pkg::PhFailed) begin
      // terminal, input is swallowed
    end else if (eof_i) begin
      phase_d    = ihrl_pkg::PhFailed;
      res_o.valid = 1'b1;
      res_o.kind  = ihrl_pkg::KindFail;
    end else begin
      unique case (phase_q)
        ihrl_pkg::PhAwait: begin
          if (char_i != ihrl_pkg::CharColon) begin
            phase_d     = ihrl_pkg::PhFailed;
            res_o.valid = 1'b1;
            res_o.kind  = ihrl_pkg::KindFail;
          end else begin
            phase_d = ihrl_pkg::PhHeader;
            digit_d = '0;
            addr_d  = '0;
          end
        end
        ihrl_pkg::PhSkip: begin
          if (char_i == ihrl_pkg::CharColon) begin
            phase_d = ihrl_pkg::PhHeader;
            digit_d = '0;
            addr_d  = '0;
          end
        end
        ihrl_pkg::PhHeader: begin
          addr_d = addr_q + addr_term;
          if (!hdr_k[0]) begin
            nibble_d = dval[3:0];
          end
          if (hdr_k == 3'd1) begin
            len_d = pair;
          end
          if (hdr_k == 3'd7) begin
            type_d  = pair;
            digit_d = '0;
            if ({1'b0, len_q} > 9'(MaxRecordBytes)) begin
              phase_d     = ihrl_pkg::PhFailed;
              res_o.valid = 1'b1;
              res_o.kind  = ihrl_pkg::KindFail;
            end else if (len_q != 8'd0) begin
              phase_d = ihrl_pkg::PhData;
            end else begin
              phase_d = ihrl_pkg::PhCheck;
            end
          end else begin
            digit_d = {6'd0, hdr_k} + 9'd1;
          end
        end
        ihrl_pkg::PhData: begin
          if (!digit_q[0]) begin
            nibble_d = dval[3:0];
            digit_d  = idx_next[8:0];
          end else begin
            if (pos == 8'd0) begin
              fdb0_d = pair;
            end
            if (pos == 8'd1) begin
              fdb1_d = pair;
            end
            if (idx_next >= {1'b0, len_q, 1'b0}) begin
              phase_d = ihrl_pkg::PhCheck;
              digit_d = '0;
            end else begin
              digit_d = idx_next[8:0];
            end
            if (type_q == ihrl_pkg::RecData) begin
              res_o.valid        = 1'b1;
              res_o.kind         = ihrl_pkg::KindData;
              res_o.load_address = {upper_q, addr_q} + {24'd0, pos};
              res_o.data_byte    = pair;
            end
          end
        end
        ihrl_pkg::PhCheck: begin
          if (digit_q == 9'd0) begin
            digit_d = 9'd1;
          end else begin
            digit_d = '0;
            if (type_q == ihrl_pkg::RecUpper) begin
              upper_d = {fdb0_q, fdb1_q};
            end
            res_o.valid       = 1'b1;
            res_o.record_kind = type_q;
            if (type_q == ihrl_pkg::RecEof) begin
              phase_d    = ihrl_pkg::PhDone;
              res_o.kind = ihrl_pkg::KindDone;
            end else begin
              phase_d    = ihrl_pkg::PhSkip;
              res_o.kind = ihrl_pkg::KindRecEnd;
            end
          end
        end
        default: begin
          phase_d = ihrl_pkg::PhFailed;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= ihrl_pkg::PhAwait;
      digit_q  <= '0;
      nibble_q <= '0;
      len_q    <= '0;
      addr_q   <= '0;
      type_q   <= '0;
      upper_q  <= '0;
      fdb0_q   <= '0;
      fdb1_q   <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      digit_q  <= digit_d;
      nibble_q <= nibble_d;
      len_q    <= len_d;
      addr_q   <= addr_d;
      type_q   <= type_d;
      upper_q  <= upper_d;
      fdb0_q   <= fdb0_d;
      fdb1_q   <= fdb1_d;
    end
  end

  a_fail_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ihrl_pkg::PhFailed |=> phase_q == ihrl_pkg::PhFailed)
    else $error("failed state left");

  a_done_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ihrl_pkg::PhDone |=> phase_q == ihrl_pkg::PhDone)
    else $error("done state left");

  a_data_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == ihrl_pkg::KindData |-> phase_q == ihrl_pkg::PhData)
    else $error("data beat outside data phase");

  a_step_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == ihrl_pkg::PhHeader |-> digit_q < 9'd8)
    else $error("header digit index out of range");

endmodule

// ===== design/intel_hex_record_loader.sv =====
// top level of the intel hex record loader: input register, parser, result register
//
//   channel  dir  tdata                                          tuser
//   s_axis   in   [7:0] char_byte                                [0] end_of_file
//   m_axis   out  [31:0] load_address [39:32] data_byte          [1:0] result_kind
//                 [47:40] record_kind
//
// one character a cycle sustained while m_axis is not stalled; each beat is held in the
// input register and gives its result, if any, from the result register
// the parse step is a single pass of logic between these two registers
// reset clears the parser to waiting for the first colon and empties both registers
// a stalled result holds the parser; the input register still takes one beat
`timescale 1ns / 1ps

module intel_hex_record_loader #(
  parameter int unsigned MaxRecordBytes = ihrl_pkg::MaxRecordBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_byte
  input  logic        s_axis_tuser,   // [0] end_of_file
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] load_address, [39:32] data_byte, [47:40] record_kind
  output logic [1:0]  m_axis_tuser    // [1:0] result_kind
);

  logic              in_valid_q;
  logic [7:0]        in_char_q;
  logic              in_eof_q;
  logic              out_valid_q;
  ihrl_pkg::result_t out_q;
  ihrl_pkg::result_t res;
  logic              step;

  // parser may move when the result register is free or being drained
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;

  ihrl_parser #(
    .MaxRecordBytes (MaxRecordBytes)
  ) u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .char_i (in_char_q),
    .eof_i  (in_eof_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (step && res.valid) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
      in_eof_q  <= s_axis_tuser;
    end
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.record_kind, out_q.data_byte, out_q.load_address};
  assign m_axis_tuser  = out_q.kind;

  a_fail_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ihrl_pkg::KindFail |-> m_axis_tdata == 48'd0)
    else $error("failure beat with payload");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |-> !step)
    else $error("result register overwritten while stalled");

  a_data_no_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser == ihrl_pkg::KindData |-> m_axis_tdata[47:40] == 8'd0)
    else $error("data beat carries record kind");

endmodule
